// ===== design/skrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrs_pkg
// Shared types and widths for the sum keyed record sorter.
// ----------------------------------------------------------------------------
package skrs_pkg;

    localparam int NAME_W  = 56;
    localparam int SCORE_W = 8;
    localparam int SCORES  = 5;
    localparam int TOTAL_W = 11;
    localparam int AVG_W   = 8;
    localparam int RANK_W  = 7;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One stored record: name, scores (first score in the low byte), total
    typedef struct packed {
        logic [TOTAL_W-1:0]         total;
        logic [SCORES*SCORE_W-1:0]  scores;
        logic [NAME_W-1:0]          name;
    } entry_t;

    // One request on the queue: record plus end-of-set flag
    typedef struct packed {
        logic   last;
        entry_t ent;
    } item_t;

    // One result leaving the back end
    typedef struct packed {
        logic               last;
        logic [RANK_W-1:0]  rank;
        logic [AVG_W-1:0]   average;
        entry_t             ent;
    } result_t;

endpackage

// ===== design/sum_keyed_record_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_keyed_record_sorter_core
// Record sorter by descending score total, with stream input and output.
// ----------------------------------------------------------------------------
// Records arrive one per cycle on the s_ channel while s_tready is high and
// are stored with the sum of their five scores; up to RECORDS records form a
// set and further ones are dropped. A record with s_tlast high closes the set:
// the block then sorts it by descending total with an exchange sort (equal
// totals keep the order that this sort gives) and sends every record with its
// total, average and rank on the m_ channel, m_tlast on the final one. The
// sort sequencer walks the record memory through its single read port, one
// entry a cycle. During sort and output the first records of the next set
// wait in a two-entry queue.
// ----------------------------------------------------------------------------
module sum_keyed_record_sorter_core
    import skrs_pkg::*;
#(
    parameter int RECORDS    = 32,
    parameter int NAME_CHARS = 7
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // record_name[55:0], score_a, score_b, score_c, score_d, score_e
    input  logic [95:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_name[55:0], out_score_a..e, out_total[10:0], out_average[7:0],
    // out_rank[6:0], zero padding
    output logic [127:0] m_tdata,
    output logic         m_tlast
);

    logic    fq_valid, fq_ready;
    item_t   fq_item;
    logic    qb_valid, qb_ready;
    item_t   qb_item;
    result_t res;

    skrs_front #(
        .NAME_CHARS (NAME_CHARS)
    ) u_front (
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_name   (s_tdata[NAME_W-1:0]),
        .in_scores (s_tdata[NAME_W +: SCORES*SCORE_W]),
        .in_last   (s_tlast),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    skrs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    skrs_back #(
        .RECORDS (RECORDS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_item    (qb_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // Pack the result onto the output stream
    assign m_tdata = {6'd0, res.rank, res.average, res.ent.total,
                      res.ent.scores, res.ent.name};
    assign m_tlast = res.last;

endmodule

// ===== design/skrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrs_front
// Front end: unpacks an incoming record, trims the name to its configured
// character count and forms the total of the five scores.
// ----------------------------------------------------------------------------
module skrs_front
    import skrs_pkg::*;
#(
    parameter int NAME_CHARS = 7
) (
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [NAME_W-1:0]          in_name,
    input  logic [SCORES*SCORE_W-1:0]  in_scores,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output item_t                      out_item
);

    localparam int NAME_BITS = (NAME_CHARS * 8 < NAME_W) ? NAME_CHARS * 8 : NAME_W;
    localparam logic [NAME_W-1:0] NAME_MASK =
        NAME_W'((65'(1) << NAME_BITS) - 65'(1));

    logic [TOTAL_W-1:0] total_sum;

    // Add the five scores
    always_comb begin
        total_sum = '0;
        for (int s = 0; s < SCORES; s++) begin
            total_sum = total_sum + TOTAL_W'(in_scores[s*SCORE_W +: SCORE_W]);
        end
    end

    // Build the queue request
    always_comb begin
        out_item.last       = in_last;
        out_item.ent.name   = in_name & NAME_MASK;
        out_item.ent.scores = in_scores;
        out_item.ent.total  = total_sum;
    end

    assign out_valid = in_valid;
    assign in_ready  = out_ready;

endmodule

// ===== design/skrs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrs_fifo
// Short request queue that decouples the front end from the sort sequencer.
// ----------------------------------------------------------------------------
module skrs_fifo
    import skrs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               push, pop;

    assign in_ready  = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/skrs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrs_back
// Back end: stores records in the record memory, runs the exchange sort on
// the closed set with one read and one write port, then streams the sorted
// records with total, average and rank through an output register.
// ----------------------------------------------------------------------------
module skrs_back
    import skrs_pkg::*;
#(
    parameter int RECORDS = 32
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int AW = $clog2(RECORDS);
    localparam int CW = $clog2(RECORDS + 1);
    localparam int AVG_PROD_W = TOTAL_W + 12;
    localparam logic [AVG_PROD_W-1:0] AVG_RECIP = AVG_PROD_W'(3277);
    localparam int AVG_SHIFT = 14;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1;
    localparam logic [2:0] S_GETI = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_WRI  = 3'd4;
    localparam logic [2:0] S_ORD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    entry_t             mem [RECORDS];
    entry_t             rd_q;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      j_reg, j_next;
    logic [AW-1:0]      k_reg, k_next;
    entry_t             held_reg, held_next;
    result_t            out_reg;
    logic               out_valid_reg;
    logic               out_load;
    logic               out_free;
    logic [CW-1:0]      n_store;
    logic [CW-1:0]      n_last;
    logic [AVG_PROD_W-1:0] avg_prod;

    assign in_ready   = (state_reg == S_LOAD);
    assign out_free   = !out_valid_reg || out_ready;
    assign n_last     = n_reg - CW'(1);
    assign n_store    = (count_reg < CW'(RECORDS)) ? count_reg + CW'(1) : count_reg;
    assign avg_prod   = AVG_PROD_W'(rd_q.total) * AVG_RECIP;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Sequence load, sort and output
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        held_next  = held_reg;
        rd_addr    = k_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(count_reg);
        wr_data    = in_item.ent;
        out_load   = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                if (in_valid) begin
                    if (count_reg < CW'(RECORDS)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (in_item.last) begin
                        n_next = n_store;
                        i_next = '0;
                        k_next = '0;
                        state_next = (n_store < CW'(2)) ? S_ORD : S_RDI;
                    end
                end
            end
            S_RDI: begin
                rd_addr    = i_reg;
                j_next     = i_reg + AW'(1);
                state_next = S_GETI;
            end
            S_GETI: begin
                held_next  = rd_q;
                rd_addr    = j_reg;
                state_next = S_CMP;
            end
            S_CMP: begin
                // swap the held entry with entry j on a strictly larger total
                if (held_reg.total < rd_q.total) begin
                    wr_en     = 1'b1;
                    wr_addr   = j_reg;
                    wr_data   = held_reg;
                    held_next = rd_q;
                end
                if (CW'(j_reg) == n_last) begin
                    state_next = S_WRI;
                end else begin
                    j_next  = j_reg + AW'(1);
                    rd_addr = j_reg + AW'(1);
                end
            end
            S_WRI: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = held_reg;
                i_next  = i_reg + AW'(1);
                if (CW'(i_reg) + CW'(1) >= n_last) begin
                    k_next     = '0;
                    state_next = S_ORD;
                end else begin
                    rd_addr    = i_reg + AW'(1);
                    j_next     = AW'(CW'(i_reg) + CW'(2));
                    state_next = S_GETI;
                end
            end
            S_ORD: begin
                rd_addr    = k_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (CW'(k_reg) == n_last) begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end else begin
                        k_next  = k_reg + AW'(1);
                        rd_addr = k_reg + AW'(1);
                    end
                end else begin
                    rd_addr = k_reg;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold loop indexes and the entry under comparison
    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        held_reg <= held_next;
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // Load the output register with the next sorted record
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.ent     <= rd_q;
            out_reg.average <= avg_prod[AVG_SHIFT +: AVG_W];
            out_reg.rank    <= RANK_W'(k_reg) + RANK_W'(1);
            out_reg.last    <= (CW'(k_reg) == n_last);
        end
    end

endmodule
